[design/rgbhsl_pkg.sv]
// rgbhsl_pkg: widths, fixed-point constants and the sideband word type
// shared by the RGB to HSL converter and its pipelined divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

  // Field widths
  localparam int CHAN_W  = 8;
  localparam int HUE_W   = 13;
  localparam int SAT_W   = 16;
  localparam int LIGHT_W = 16;

  // Stream word widths (fields packed from bit 0, padded to bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Divider shapes: quotient bits and pipeline stages
  localparam int DIV_STAGES = 4;
  localparam int SAT_Q_W    = 16;
  localparam int HUE_Q_W    = 12;

  // Fixed-point constants
  localparam int CHAN_MAX    = 255;        // one channel at full scale
  localparam int SUM_MAX     = 510;        // max + min at full scale
  localparam int SAT_ONE     = 65535;      // Q0.16 value for one
  localparam int LIGHT_SCALE = 257;        // 65535/510 = 257/2
  localparam int HUE_SIXTY   = 960;        // 60 degrees in sixteenths
  localparam int HUE_GREEN   = 1920;       // 120 degrees
  localparam int HUE_BLUE    = 3840;       // 240 degrees
  localparam int HUE_FULL    = 5760;       // 360 degrees

  // Per-pixel sideband carried alongside the divider
  typedef struct packed {
    logic               grey;   // max == min: hue and saturation forced to zero
    logic               neg;    // hue offset is negative, subtract the ceiling
    logic [HUE_W-1:0]   base;   // sector base in sixteenths of a degree
    logic [LIGHT_W-1:0] light;  // finished lightness
  } hsl_side_t;

endpackage

`default_nettype wire

[design/rgbhsl_div.sv]
// rgbhsl_div: pipelined restoring divider, STAGES register stages with
// Q_W/STAGES quotient bits resolved in each. Needs num < den * 2**Q_W.
// Depends on rgbhsl_pkg for default shapes.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_div #(
  parameter int Q_W    = rgbhsl_pkg::SAT_Q_W,
  parameter int DEN_W  = rgbhsl_pkg::CHAN_W,
  parameter int STAGES = rgbhsl_pkg::DIV_STAGES
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [Q_W+DEN_W-1:0]   num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [Q_W-1:0]         quo,
  output logic      [DEN_W-1:0]       rem
);

  localparam int NUM_W = Q_W + DEN_W;
  localparam int STEP  = Q_W / STAGES;

  // Per-stage partial remainder, numerator/quotient shift word and divisor
  logic [DEN_W-1:0] rem_q  [STAGES];
  logic [Q_W-1:0]   word_q [STAGES];
  logic [DEN_W-1:0] den_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] rem_next;
    logic [Q_W-1:0]   word_in;
    logic [Q_W-1:0]   word_next;
    logic [DEN_W-1:0] den_in;

    if (k == 0) begin : g_first
      // high numerator bits are already below the divisor
      assign rem_in  = num[NUM_W-1:Q_W];
      assign word_in = num[Q_W-1:0];
      assign den_in  = den;
    end else begin : g_chain
      assign rem_in  = rem_q[k-1];
      assign word_in = word_q[k-1];
      assign den_in  = den_q[k-1];
    end

    // STEP shift-and-subtract steps; quotient bits enter at the bottom
    always_comb begin : step
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] rem_v;
      logic [Q_W-1:0]   word_v;
      rem_v  = rem_in;
      word_v = word_in;
      trial  = '0;
      for (int j = 0; j < STEP; j++) begin
        trial  = {rem_v, word_v[Q_W-1]};
        word_v = {word_v[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial     = trial - {1'b0, den_in};
          word_v[0] = 1'b1;
        end
        rem_v = trial[DEN_W-1:0];
      end
      rem_next  = rem_v;
      word_next = word_v;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= rem_next;
        word_q[k] <= word_next;
        den_q[k]  <= den_in;
      end
    end
  end

  assign quo = word_q[STAGES-1];
  assign rem = rem_q[STAGES-1];

endmodule

`default_nettype wire

[design/rgb_to_hsl_top.sv]
// rgb_to_hsl_top: stream converter from 8-bit RGB pixels to hue,
// saturation and lightness. Depends on rgbhsl_pkg and rgbhsl_div.
`timescale 1ns / 1ps
`default_nettype none

// One pixel word enters per clock and one HSL word leaves per clock while
// the output is not stalled. There are seven register stages (input
// register, min/max stage, four divider stages, output register), and a
// pixel's valid bit moves through them in that order to m_axis_tvalid. The
// depth is set by the two 8-bit-divisor restoring dividers that run side
// by side, four quotient bits (saturation) and three (hue) per stage.
// A stall on the output freezes the whole pipeline; s_axis_tready is high
// whenever the output register is empty or being taken. No state is kept
// between pixels and there is no start-up sweep after reset.
module rgb_to_hsl_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // hue[12:0], saturation[28:13],
                                           // lightness[44:29], zero[47:45]
);
  import rgbhsl_pkg::*;

  localparam int SAT_NUM_W = SAT_Q_W + CHAN_W;
  localparam int HUE_NUM_W = HUE_Q_W + CHAN_W;

  logic en;

  // Stage 0: input register
  logic              v0;
  logic [CHAN_W-1:0] red0, green0, blue0;

  // Stage 1: divider operands and sideband
  logic                 v1;
  logic [SAT_NUM_W-1:0] sat_num;
  logic [CHAN_W-1:0]    sat_den;
  logic [HUE_NUM_W-1:0] hue_num;
  logic [CHAN_W-1:0]    hue_den;
  hsl_side_t            side1;

  logic [SAT_NUM_W-1:0] sat_num_next;
  logic [CHAN_W-1:0]    sat_den_next;
  logic [HUE_NUM_W-1:0] hue_num_next;
  logic [CHAN_W-1:0]    hue_den_next;
  hsl_side_t            side1_next;

  // Valid and sideband line alongside the divider
  logic [DIV_STAGES-1:0] v_div;
  hsl_side_t             side_div [DIV_STAGES];

  logic [SAT_Q_W-1:0] sat_quo;
  logic [CHAN_W-1:0]  sat_rem;
  logic [HUE_Q_W-1:0] hue_quo;
  logic [CHAN_W-1:0]  hue_rem;

  // Output register
  logic [HUE_W-1:0]   out_hue;
  logic [SAT_W-1:0]   out_sat;
  logic [LIGHT_W-1:0] out_light;
  logic [HUE_W-1:0]   out_hue_next;

  // Pipeline moves whenever the output word is empty or taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0            <= 1'b0;
      v1            <= 1'b0;
      v_div         <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v0            <= s_axis_tvalid;
      v1            <= v0;
      v_div         <= {v_div[DIV_STAGES-2:0], v1};
      m_axis_tvalid <= v_div[DIV_STAGES-1];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (en) begin
      red0   <= s_axis_tdata[7:0];
      green0 <= s_axis_tdata[15:8];
      blue0  <= s_axis_tdata[23:16];
    end
  end

  // Stage 1: max/min, lightness, divider operands, hue sector
  always_comb begin
    logic [CHAN_W-1:0] mx, mn, d, mag;
    logic [CHAN_W:0]   s, other;
    logic [16:0]       light_x2;
    logic              red_max, green_max, neg;
    mx = red0;
    mn = red0;
    if (green0 > mx) mx = green0;
    if (blue0 > mx)  mx = blue0;
    if (green0 < mn) mn = green0;
    if (blue0 < mn)  mn = blue0;
    d     = mx - mn;
    s     = {1'b0, mx} + {1'b0, mn};
    other = (CHAN_W+1)'(SUM_MAX) - s;

    // lightness = floor(s * 257 / 2)
    light_x2 = 17'(s) * 17'(LIGHT_SCALE);

    // saturation: d * 65535 over s or 510 - s
    sat_num_next = SAT_NUM_W'(d) * SAT_NUM_W'(SAT_ONE);
    if (s <= (CHAN_W+1)'(CHAN_MAX)) sat_den_next = s[CHAN_W-1:0];
    else                            sat_den_next = other[CHAN_W-1:0];

    // hue sector: red, then green, then blue on ties
    red_max   = (red0 >= green0) && (red0 >= blue0);
    green_max = !red_max && (green0 >= blue0);
    neg       = 1'b0;
    mag       = '0;
    side1_next.base = '0;
    if (red_max) begin
      neg = green0 < blue0;
      mag = neg ? (blue0 - green0) : (green0 - blue0);
      side1_next.base = neg ? HUE_W'(HUE_FULL) : '0;
    end else if (green_max) begin
      neg = blue0 < red0;
      mag = neg ? (red0 - blue0) : (blue0 - red0);
      side1_next.base = HUE_W'(HUE_GREEN);
    end else begin
      neg = red0 < green0;
      mag = neg ? (green0 - red0) : (red0 - green0);
      side1_next.base = HUE_W'(HUE_BLUE);
    end
    hue_num_next = HUE_NUM_W'(mag) * HUE_NUM_W'(HUE_SIXTY);
    hue_den_next = d;

    side1_next.grey  = (d == '0);
    side1_next.neg   = neg;
    side1_next.light = light_x2[16:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_num <= sat_num_next;
      sat_den <= sat_den_next;
      hue_num <= hue_num_next;
      hue_den <= hue_den_next;
      side1   <= side1_next;
    end
  end

  // Dividers, stage-aligned
  rgbhsl_div #(
    .Q_W    (SAT_Q_W),
    .DEN_W  (CHAN_W),
    .STAGES (DIV_STAGES)
  ) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo),
    .rem (sat_rem)
  );

  rgbhsl_div #(
    .Q_W    (HUE_Q_W),
    .DEN_W  (CHAN_W),
    .STAGES (DIV_STAGES)
  ) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo),
    .rem (hue_rem)
  );

  // Sideband line, same depth as the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      side_div[0] <= side1;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_div[k] <= side_div[k-1];
      end
    end
  end

  // Final hue: zero if grey, base plus floor, or base minus ceiling if negative
  always_comb begin
    hsl_side_t sd;
    sd = side_div[DIV_STAGES-1];
    if (sd.grey) begin
      out_hue_next = '0;
    end else if (sd.neg) begin
      out_hue_next = sd.base - HUE_W'(hue_quo) - HUE_W'(hue_rem != '0);
    end else begin
      out_hue_next = sd.base + HUE_W'(hue_quo);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_hue   <= out_hue_next;
      out_sat   <= side_div[DIV_STAGES-1].grey ? '0 : sat_quo;
      out_light <= side_div[DIV_STAGES-1].light;
    end
  end

  assign m_axis_tdata = {3'b000, out_light, out_sat, out_hue};

  // Checks
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !v0 && !v1 && (v_div == '0)))
    else $error("pipeline valid bits not cleared by reset");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_hue < HUE_W'(HUE_FULL)))
    else $error("hue outside one full turn");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(v_div) && $stable(v1) && $stable(v0)))
    else $error("pipeline moved during an output stall");

  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    (en && v_div[DIV_STAGES-1] && side_div[DIV_STAGES-1].grey)
      |=> (m_axis_tvalid && (out_hue == '0) && (out_sat == '0)))
    else $error("grey pixel gave non-zero hue or saturation");

  a_sat_light: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_sat != '0)) |-> (out_light != '0))
    else $error("coloured pixel with zero lightness");

endmodule

`default_nettype wire

[sim/rgb_to_hsl_top_test.sv]
// rgb_to_hsl_top_test: self-checking bench for the RGB to HSL stream converter.
// Random gaps on the pixel side and random back-pressure on the HSL side.
// Each output word is checked against a fixed-point prediction. Depends on rgbhsl_pkg.
`timescale 1ns / 1ps

typedef struct {
  logic [rgbhsl_pkg::CHAN_W-1:0]  red;
  logic [rgbhsl_pkg::CHAN_W-1:0]  green;
  logic [rgbhsl_pkg::CHAN_W-1:0]  blue;
  logic [rgbhsl_pkg::HUE_W-1:0]   hue;
  logic [rgbhsl_pkg::SAT_W-1:0]   sat;
  logic [rgbhsl_pkg::LIGHT_W-1:0] light;
} hsl_expect_t;

// Holds the HSL words still owed by the converter and checks each arriving word
class hsl_scoreboard;
  hsl_expect_t owed_hsl[$];
  int          mismatch_count = 0;

  // floor(num / den) for den > 0, either sign of num
  static function int floor_quot(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  static function hsl_expect_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int red, grn, blu, mx, mn, dif, sum, den, h;
    hsl_expect_t res;
    red = int'(r);
    grn = int'(g);
    blu = int'(b);
    mx  = red;
    mn  = red;
    if (grn > mx) mx = grn;
    if (blu > mx) mx = blu;
    if (grn < mn) mn = grn;
    if (blu < mn) mn = blu;
    dif = mx - mn;
    sum = mx + mn;
    res.red   = r;
    res.green = g;
    res.blue  = b;
    res.light = 16'((sum * rgbhsl_pkg::SAT_ONE) / rgbhsl_pkg::SUM_MAX);
    res.sat   = '0;
    h = 0;
    // grey leaves hue and saturation at zero
    if (dif != 0) begin
      den = (sum <= rgbhsl_pkg::CHAN_MAX) ? sum : rgbhsl_pkg::SUM_MAX - sum;
      res.sat = 16'((dif * rgbhsl_pkg::SAT_ONE) / den);
      // ties go to red, then green
      if (mx == red) begin
        h = floor_quot(rgbhsl_pkg::HUE_SIXTY * (grn - blu), dif);
        if (h < 0) h += rgbhsl_pkg::HUE_FULL;
      end else if (mx == grn) begin
        h = floor_quot(rgbhsl_pkg::HUE_GREEN * dif + rgbhsl_pkg::HUE_SIXTY * (blu - red), dif);
      end else begin
        h = floor_quot(rgbhsl_pkg::HUE_BLUE * dif + rgbhsl_pkg::HUE_SIXTY * (red - grn), dif);
      end
    end
    res.hue = h[rgbhsl_pkg::HUE_W-1:0];
    return res;
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    owed_hsl.push_back(convert_pixel(r, g, b));
  endfunction

  function int pending();
    return owed_hsl.size();
  endfunction

  function void check_word(logic [rgbhsl_pkg::OUT_DATA_W-1:0] word);
    hsl_expect_t exp_hsl;
    logic [rgbhsl_pkg::HUE_W-1:0]   got_hue;
    logic [rgbhsl_pkg::SAT_W-1:0]   got_sat;
    logic [rgbhsl_pkg::LIGHT_W-1:0] got_light;
    got_hue   = word[12:0];
    got_sat   = word[28:13];
    got_light = word[44:29];
    if (owed_hsl.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("HSL word %h arrived with no pixel outstanding", word);
      return;
    end
    exp_hsl = owed_hsl.pop_front();
    if (got_hue !== exp_hsl.hue || got_sat !== exp_hsl.sat || got_light !== exp_hsl.light) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("rgb %0d,%0d,%0d: hue exp %0d got %0d, sat exp %0d got %0d, light exp %0d got %0d",
                 exp_hsl.red, exp_hsl.green, exp_hsl.blue, exp_hsl.hue, got_hue,
                 exp_hsl.sat, got_sat, exp_hsl.light, got_light);
    end
  endfunction
endclass

module rgb_to_hsl_top_test;
  import rgbhsl_pkg::*;

  localparam int LATENCY    = 7;
  localparam int IDLE_LIMIT = 1000;
  localparam int N_RANDOM   = 1400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // hue[12:0], saturation[28:13], lightness[44:29]

  hsl_scoreboard sb = new();
  bit            steady = 1'b0;   // no gaps on either side while set
  int unsigned   sink_hold = 0;

  rgb_to_hsl_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // HSL side back-pressure
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata);
  end

  // one pixel word, valid held until taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(r, g, b);
  endtask

  function automatic logic [7:0] near_level(int base);
    int v;
    v = base + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > CHAN_MAX) v = CHAN_MAX;
    return v[7:0];
  endfunction

  task automatic send_random_pixel();
    logic [7:0] r, g, b, t;
    int roll, base;
    roll = $urandom_range(0, 99);
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    if (roll >= 60 && roll < 75) begin
      // near grey: tiny differences
      base = $urandom_range(0, 255);
      r = near_level(base);
      g = near_level(base);
      b = near_level(base);
    end else if (roll >= 75 && roll < 90) begin
      // two channels equal, unless red is redrawn afterwards
      t = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: g = r;
        1: b = g;
        default: b = r;
      endcase
      if ($urandom_range(0, 1) == 1) r = t;
    end else if (roll >= 90) begin
      // a channel pinned at an extreme
      t = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
      case ($urandom_range(0, 2))
        0: r = t;
        1: g = t;
        default: b = t;
      endcase
    end
    send_pixel(r, g, b);
  endtask

  // stall watchdog
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: greys, primaries, ties, wrap, half lightness edge
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd1);
    send_pixel(8'd200, 8'd55,  8'd100);
    send_pixel(8'd200, 8'd56,  8'd100);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd85,  8'd170, 8'd255);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd10,  8'd20,  8'd30);
    send_pixel(8'd30,  8'd20,  8'd10);

    // random, with one stretch at full rate on both sides
    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 400 && n < 600);
      send_random_pixel();
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
